// ----- hdl/slt_pkg.sv -----
// Shared types, token codes and character classes for the small language tokenizer.
package slt_pkg;

    localparam int unsigned FIELD_BITS = 16;
    localparam logic [FIELD_BITS-1:0] FIELD_MAX = 16'hFFFF;
    localparam int unsigned TDATA_BITS = 40;

    // Token kind codes as they appear on the result stream
    typedef enum logic [3:0] {
        K_EOF     = 4'd0,
        K_WS      = 4'd1,
        K_IDENT   = 4'd2,
        K_IF      = 4'd3,
        K_INT     = 4'd4,
        K_NUMBER  = 4'd5,
        K_PLUS    = 4'd6,
        K_MINUS   = 4'd7,
        K_ASSIGN  = 4'd8,
        K_EQUAL   = 4'd9,
        K_LBRACE  = 4'd10,
        K_RBRACE  = 4'd11,
        K_SEMI    = 4'd12,
        K_LPAREN  = 4'd13,
        K_RPAREN  = 4'd14,
        K_UNKNOWN = 4'd15
    } kind_t;

    // Open run that waits for the byte that ends it
    typedef enum logic [3:0] {
        P_NONE   = 4'b0001,
        P_IDENT  = 4'b0010,
        P_NUMBER = 4'b0100,
        P_EQ     = 4'b1000
    } pend_t;

    // Keyword prefix seen so far in an identifier run
    typedef enum logic [4:0] {
        KW_NONE = 5'b00001,
        KW_I    = 5'b00010,
        KW_IF   = 5'b00100,
        KW_IN   = 5'b01000,
        KW_INT  = 5'b10000
    } kw_t;

    typedef struct packed {
        logic                  last;
        logic [FIELD_BITS-1:0] length;
        logic [FIELD_BITS-1:0] start;
        kind_t                 kind;
    } token_t;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_LO_I   = 8'h69;
    localparam logic [7:0] CH_LO_N   = 8'h6E;
    localparam logic [7:0] CH_LO_T   = 8'h74;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= CH_LO_A && b <= CH_LO_Z) || (b >= CH_UP_A && b <= CH_UP_Z);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    function automatic logic is_ws(input logic [7:0] b);
        return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
    endfunction

    // Kind of a byte that forms a token on its own
    function automatic kind_t single_kind(input logic [7:0] b);
        kind_t k;
        case (b)
            CH_PLUS:   k = K_PLUS;
            CH_MINUS:  k = K_MINUS;
            CH_LBRACE: k = K_LBRACE;
            CH_RBRACE: k = K_RBRACE;
            CH_SEMI:   k = K_SEMI;
            CH_LPAREN: k = K_LPAREN;
            CH_RPAREN: k = K_RPAREN;
            default:   k = is_ws(b) ? K_WS : K_UNKNOWN;
        endcase
        return k;
    endfunction

    // Advance the keyword prefix by one letter
    function automatic kw_t next_kw(input kw_t p, input logic [7:0] b);
        kw_t n;
        n = KW_NONE;
        case (p)
            KW_I:
            begin
                if (b == CH_LO_F)
                    n = KW_IF;
                else if (b == CH_LO_N)
                    n = KW_IN;
            end
            KW_IN:
            begin
                if (b == CH_LO_T)
                    n = KW_INT;
            end
            default: n = KW_NONE;
        endcase
        return n;
    endfunction

endpackage

// ----- hdl/small_language_tokenizer.sv -----
// Top level of the small language tokenizer: byte stream in, token stream out.
//
//  Channel | Signals                         | Carries
//  --------+---------------------------------+----------------------------------------------
//  s_*     | s_tvalid s_tready s_tdata[7:0]  | one source byte per transaction
//  m_*     | m_tvalid m_tready m_tdata m_tlast| one token per transaction, tlast = last_of_run
//
//  One byte is taken per cycle while s_tready is high; state and tokens settle at the same clock edge.
//  A byte yields zero, one or two tokens; a three-entry token queue sets the rate:
//  s_tready is high while the queue holds at most one token, so single-token bytes
//  stream at one per cycle while m_tready is high, and a two-token byte can drop s_tready.
//  rst_n clears position, open run, keyword prefix and the queue asynchronously.
//  A stalled m_tready holds the head token; s_tready drops once two tokens wait.
module small_language_tokenizer #(
    parameter int unsigned OFFSET_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] text_byte
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [slt_pkg::TDATA_BITS-1:0] m_tdata,   // [3:0] token_kind, [19:4] token_start,
                                                      // [35:20] token_length, [39:36] zero
    output logic                           m_tlast    // last_of_run
);
    import slt_pkg::*;

    localparam int unsigned WIDE_BITS = (OFFSET_BITS > FIELD_BITS) ? OFFSET_BITS : FIELD_BITS;
    localparam int unsigned Q_DEPTH   = 3;

    // Clamp an offset or a length to the token field width
    function automatic logic [FIELD_BITS-1:0] sat_field(input logic [OFFSET_BITS-1:0] v);
        logic [WIDE_BITS-1:0] w;
        w = WIDE_BITS'(v);
        return (w > WIDE_BITS'(FIELD_MAX)) ? FIELD_MAX : w[FIELD_BITS-1:0];
    endfunction

    logic [OFFSET_BITS-1:0] pos_reg, pos_next, pos_inc;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    pend_t                  pend_reg, pend_next;
    kw_t                    kw_reg, kw_next;
    token_t                 q_reg [Q_DEPTH];
    token_t                 q_next [Q_DEPTH];
    logic [1:0]             cnt_reg, cnt_next;

    token_t                 res [2];
    logic [1:0]             res_cnt;
    logic                   done;
    logic                   push, pop;
    logic [1:0]             base;
    kind_t                  run_kind;

    assign pos_inc  = (pos_reg == {OFFSET_BITS{1'b1}}) ? pos_reg : pos_reg + OFFSET_BITS'(1);
    assign s_tready = (cnt_reg <= 2'd1);
    assign m_tvalid = (cnt_reg != 2'd0);
    assign push     = s_tvalid && s_tready;
    assign pop      = m_tvalid && m_tready;
    assign m_tdata  = {4'b0000, q_reg[0].length, q_reg[0].start, q_reg[0].kind};
    assign m_tlast  = q_reg[0].last;
    assign run_kind = (kw_reg == KW_IF) ? K_IF : (kw_reg == KW_INT) ? K_INT : K_IDENT;

    // Tokenize one byte: close the open run, then handle the byte itself
    always_comb
    begin
        pos_next   = pos_reg;
        start_next = start_reg;
        pend_next  = pend_reg;
        kw_next    = kw_reg;
        res[0]     = '0;
        res[1]     = '0;
        res_cnt    = 2'd0;
        done       = 1'b0;

        case (pend_reg)
            P_EQ:
            begin
                pend_next = P_NONE;
                res_cnt   = 2'd1;
                if (s_tdata == CH_EQ)
                begin
                    res[0]   = '{1'b0, 16'd2, sat_field(start_reg), K_EQUAL};
                    pos_next = pos_inc;
                    done     = 1'b1;
                end
                else
                begin
                    res[0] = '{1'b0, 16'd1, sat_field(start_reg), K_ASSIGN};
                end
            end
            P_IDENT:
            begin
                if (is_alpha(s_tdata))
                begin
                    kw_next  = next_kw(kw_reg, s_tdata);
                    pos_next = pos_inc;
                    done     = 1'b1;
                end
                else
                begin
                    res[0]    = '{1'b0, sat_field(pos_reg - start_reg), sat_field(start_reg),
                                  run_kind};
                    res_cnt   = 2'd1;
                    pend_next = P_NONE;
                    kw_next   = KW_NONE;
                end
            end
            P_NUMBER:
            begin
                if (is_digit(s_tdata))
                begin
                    pos_next = pos_inc;
                    done     = 1'b1;
                end
                else
                begin
                    res[0]    = '{1'b0, sat_field(pos_reg - start_reg), sat_field(start_reg),
                                  K_NUMBER};
                    res_cnt   = 2'd1;
                    pend_next = P_NONE;
                end
            end
            default: ;
        endcase

        if (!done)
        begin
            if (s_tdata == CH_NUL)
            begin
                res[res_cnt[0]] = '{1'b0, 16'd1, sat_field(pos_reg), K_EOF};
                res_cnt         = res_cnt + 2'd1;
                pos_next        = '0;
            end
            else if (is_alpha(s_tdata))
            begin
                pend_next  = P_IDENT;
                start_next = pos_reg;
                kw_next    = (s_tdata == CH_LO_I) ? KW_I : KW_NONE;
                pos_next   = pos_inc;
            end
            else if (is_digit(s_tdata))
            begin
                pend_next  = P_NUMBER;
                start_next = pos_reg;
                pos_next   = pos_inc;
            end
            else if (s_tdata == CH_EQ)
            begin
                pend_next  = P_EQ;
                start_next = pos_reg;
                pos_next   = pos_inc;
            end
            else
            begin
                res[res_cnt[0]] = '{1'b0, 16'd1, sat_field(pos_reg), single_kind(s_tdata)};
                res_cnt         = res_cnt + 2'd1;
                pos_next        = pos_inc;
            end
        end

        // Mark the final token of this byte
        if (res_cnt == 2'd2)
            res[1].last = 1'b1;
        else
            res[0].last = 1'b1;
    end

    // Pop the head, then append this byte's tokens behind what remains
    always_comb
    begin
        base = cnt_reg - {1'b0, pop};
        for (int i = 0; i < Q_DEPTH; i++)
            q_next[i] = q_reg[i];
        if (pop)
        begin
            for (int i = 0; i < Q_DEPTH - 1; i++)
                q_next[i] = q_reg[i + 1];
        end
        if (push)
        begin
            for (int i = 0; i < Q_DEPTH; i++)
            begin
                if (res_cnt != 2'd0 && 2'(i) == base)
                    q_next[i] = res[0];
                if (res_cnt == 2'd2 && 2'(i) == base + 2'd1)
                    q_next[i] = res[1];
            end
        end
        cnt_next = base + (push ? res_cnt : 2'd0);
    end

    // Hold scanner state, advance it on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            start_reg <= '0;
            pend_reg  <= P_NONE;
            kw_reg    <= KW_NONE;
            cnt_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                pos_reg   <= pos_next;
                start_reg <= start_next;
                pend_reg  <= pend_next;
                kw_reg    <= kw_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    // Token queue payload
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < Q_DEPTH; i++)
            q_reg[i] <= q_next[i];
    end

endmodule

// ----- hdl/slt_checker.sv -----
// Port-level checks on the tokenizer's token stream, bound to the top level.
module slt_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [slt_pkg::TDATA_BITS-1:0] m_tdata,
    input logic                           m_tlast
);
    import slt_pkg::*;

    // A stalled token holds its contents
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("token changed while stalled");

    // A two-byte equal token always spans two bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3:0] == K_EQUAL |-> m_tdata[35:20] == 16'd2)
        else $error("equal token length is not two");

    // End of text is one byte long and closes its run
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3:0] == K_EOF |-> m_tdata[35:20] == 16'd1 && m_tlast)
        else $error("end-of-text token malformed");

    // Single-byte kinds carry length one
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[3:0] == K_WS || m_tdata[3:0] == K_PLUS ||
                     m_tdata[3:0] == K_MINUS || m_tdata[3:0] == K_ASSIGN ||
                     m_tdata[3:0] == K_LBRACE || m_tdata[3:0] == K_RBRACE ||
                     m_tdata[3:0] == K_SEMI || m_tdata[3:0] == K_LPAREN ||
                     m_tdata[3:0] == K_RPAREN || m_tdata[3:0] == K_UNKNOWN)
        |-> m_tdata[35:20] == 16'd1)
        else $error("single-byte token with wrong length");

    // Pad bits above the length stay zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[39:36] == 4'b0000)
        else $error("token pad bits set");

endmodule

bind small_language_tokenizer slt_checker u_slt_checker (.*);

// ----- verif/testbench.sv -----
// Self-checking testbench for the small language tokenizer: byte stream in, token stream out.
`timescale 1ns / 1ps

module testbench;

    import slt_pkg::*;

    // Expected-token tracker: mirrors the lexer state and queues the tokens each byte yields
    class token_tracker;
        token_t      tokens_due[$];
        token_t      step_toks[$];
        int          mismatches;
        logic [15:0] cur_pos;
        logic [15:0] run_origin;
        pend_t       open_run;
        kw_t         prefix;

        function new();
            cur_pos    = '0;
            run_origin = '0;
            open_run   = P_NONE;
            prefix     = KW_NONE;
            mismatches = 0;
        endfunction

        function int pending();
            return tokens_due.size();
        endfunction

        // Print one line and count the mismatch
        task report(input string msg);
            $display("ERROR: %s", msg);
            mismatches++;
        endtask

        // Advance the text offset, holding at the top of the offset range
        function void bump();
            if (cur_pos != 16'hFFFF)
                cur_pos++;
        endfunction

        function void add_tok(input kind_t k, input logic [15:0] st, input logic [15:0] len);
            token_t t;
            t.kind   = k;
            t.start  = st;
            t.length = len;
            t.last   = 1'b0;
            step_toks.push_back(t);
        endfunction

        function bit is_letter(input logic [7:0] b);
            return (b >= CH_LO_A && b <= CH_LO_Z) || (b >= CH_UP_A && b <= CH_UP_Z);
        endfunction

        function bit is_numeral(input logic [7:0] b);
            return b >= CH_ZERO && b <= CH_NINE;
        endfunction

        function bit is_blank(input logic [7:0] b);
            return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
        endfunction

        function kind_t lone_kind(input logic [7:0] b);
            case (b)
                CH_PLUS:   return K_PLUS;
                CH_MINUS:  return K_MINUS;
                CH_LBRACE: return K_LBRACE;
                CH_RBRACE: return K_RBRACE;
                CH_SEMI:   return K_SEMI;
                CH_LPAREN: return K_LPAREN;
                CH_RPAREN: return K_RPAREN;
                default:   return is_blank(b) ? K_WS : K_UNKNOWN;
            endcase
        endfunction

        // Track the "if" / "int" prefix; anything else kills the keyword
        function kw_t grow(input kw_t p, input logic [7:0] b);
            if (p == KW_I && b == CH_LO_F)
                return KW_IF;
            if (p == KW_I && b == CH_LO_N)
                return KW_IN;
            if (p == KW_IN && b == CH_LO_T)
                return KW_INT;
            return KW_NONE;
        endfunction

        // Compute the tokens caused by one accepted byte
        function void note_byte(input logic [7:0] b);
            token_t t;
            bit     consumed;
            step_toks.delete();
            consumed = 1'b0;

            // Close or extend the open run first
            case (open_run)
                P_EQ:
                begin
                    open_run = P_NONE;
                    if (b == CH_EQ)
                    begin
                        add_tok(K_EQUAL, run_origin, 16'd2);
                        bump();
                        consumed = 1'b1;
                    end
                    else
                        add_tok(K_ASSIGN, run_origin, 16'd1);
                end
                P_IDENT:
                begin
                    if (is_letter(b))
                    begin
                        prefix = grow(prefix, b);
                        bump();
                        consumed = 1'b1;
                    end
                    else
                    begin
                        add_tok(prefix == KW_IF ? K_IF : prefix == KW_INT ? K_INT : K_IDENT,
                                run_origin, cur_pos - run_origin);
                        open_run = P_NONE;
                        prefix   = KW_NONE;
                    end
                end
                P_NUMBER:
                begin
                    if (is_numeral(b))
                    begin
                        bump();
                        consumed = 1'b1;
                    end
                    else
                    begin
                        add_tok(K_NUMBER, run_origin, cur_pos - run_origin);
                        open_run = P_NONE;
                    end
                end
                default: ;
            endcase

            // Then handle the byte itself
            if (!consumed)
            begin
                if (b == CH_NUL)
                begin
                    add_tok(K_EOF, cur_pos, 16'd1);
                    cur_pos = '0;
                end
                else if (is_letter(b))
                begin
                    open_run   = P_IDENT;
                    run_origin = cur_pos;
                    prefix     = (b == CH_LO_I) ? KW_I : KW_NONE;
                    bump();
                end
                else if (is_numeral(b))
                begin
                    open_run   = P_NUMBER;
                    run_origin = cur_pos;
                    bump();
                end
                else if (b == CH_EQ)
                begin
                    open_run   = P_EQ;
                    run_origin = cur_pos;
                    bump();
                end
                else
                begin
                    add_tok(lone_kind(b), cur_pos, 16'd1);
                    bump();
                end
            end

            // Mark the final token of this byte
            if (step_toks.size() > 0)
            begin
                t = step_toks.pop_back();
                t.last = 1'b1;
                step_toks.push_back(t);
            end
            foreach (step_toks[i])
                tokens_due.push_back(step_toks[i]);
        endfunction

        // Compare one output transaction against the oldest expected token
        task check_token(input logic [TDATA_BITS-1:0] data, input logic last);
            token_t want;
            if (tokens_due.size() == 0)
            begin
                report($sformatf("unexpected token kind %0d start %0d length %0d",
                                 data[3:0], data[19:4], data[35:20]));
                return;
            end
            want = tokens_due.pop_front();
            if (data[3:0] !== want.kind)
                report($sformatf("kind %0d, want %0d (start %0d)",
                                 data[3:0], want.kind, want.start));
            if (data[19:4] !== want.start)
                report($sformatf("start %0d, want %0d", data[19:4], want.start));
            if (data[35:20] !== want.length)
                report($sformatf("length %0d, want %0d (start %0d)",
                                 data[35:20], want.length, want.start));
            if (last !== want.last)
                report($sformatf("tlast %0b, want %0b (start %0d)", last, want.last, want.start));
            if (data[TDATA_BITS-1:36] !== '0)
                report($sformatf("pad bits %h not zero", data[TDATA_BITS-1:36]));
        endtask
    endclass

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata  = 8'h00;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [TDATA_BITS-1:0] m_tdata;
    logic                  m_tlast;

    token_tracker tracker = new();
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int bytes_sent    = 0;

    small_language_tokenizer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    // Stall the token stream at random
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    // Note accepted bytes before checking tokens seen at the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                tracker.note_byte(s_tdata);
            if (m_tvalid && m_tready)
                tracker.check_token(m_tdata, m_tlast);
        end
    end

    // Present one byte, with random idle cycles ahead of it, and wait for the transaction
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // Send one random lexeme: mostly well-formed words, with some noise
    task automatic send_lexeme();
        int         pick;
        int         n;
        logic [7:0] ch;
        pick = $urandom_range(99);
        if (pick < 20)
        begin
            if ($urandom_range(1))
            begin
                case ($urandom_range(7))
                    0:       send_text("if");
                    1:       send_text("int");
                    2:       send_text("in");
                    3:       send_text("i");
                    4:       send_text("ifx");
                    5:       send_text("inte");
                    6:       send_text("If");
                    default: send_text("it");
                endcase
            end
            else
            begin
                n = $urandom_range(1, 6);
                repeat (n)
                begin
                    ch = 8'(($urandom_range(1) ? CH_LO_A : CH_UP_A) + $urandom_range(25));
                    send_byte(ch);
                end
            end
        end
        else if (pick < 32)
        begin
            n = $urandom_range(1, 5);
            repeat (n)
            begin
                ch = 8'(CH_ZERO + $urandom_range(9));
                send_byte(ch);
            end
        end
        else if (pick < 44)
        begin
            send_byte(CH_EQ);
            if ($urandom_range(1))
                send_byte(CH_EQ);
        end
        else if (pick < 62)
        begin
            case ($urandom_range(6))
                0:       send_byte(CH_PLUS);
                1:       send_byte(CH_MINUS);
                2:       send_byte(CH_LBRACE);
                3:       send_byte(CH_RBRACE);
                4:       send_byte(CH_SEMI);
                5:       send_byte(CH_LPAREN);
                default: send_byte(CH_RPAREN);
            endcase
        end
        else if (pick < 74)
        begin
            n  = $urandom_range(5);
            ch = (n == 5) ? CH_SPACE : 8'(CH_TAB + n);
            send_byte(ch);
        end
        else if (pick < 80)
            send_byte(CH_NUL);
        else
        begin
            ch = 8'($urandom_range(255));
            send_byte(ch);
        end
    endtask

    // Run random lexemes under one idle/stall setting
    task automatic run_phase(input int idle, input int stall, input int count);
        int first;
        send_idle_pct = idle;
        stall_pct     = stall;
        first         = bytes_sent;
        while (bytes_sent - first < count)
            send_lexeme();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed text: keywords, runs, both '=' outcomes, every single-byte token
        send_text("int(if{Zx79===}-+;)\t\r");
        send_byte(8'hFF);
        send_byte(CH_SPACE);
        send_byte(CH_EQ);
        send_byte(CH_NUL);

        // Close a long identifier with whitespace
        send_text("ab ");
        repeat (30)
            send_byte(CH_LO_A);
        send_byte(CH_SPACE);
        send_byte(8'h0B);
        send_byte(CH_NUL);

        run_phase(0, 0, 95);
        run_phase(84, 0, 95);
        run_phase(0, 84, 95);
        run_phase(31, 31, 95);
        send_byte(CH_NUL);
        s_tvalid <= 1'b0;

        // Drain outstanding tokens, then watch for strays
        @(posedge clk);
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        if (tracker.pending() != 0)
            tracker.report($sformatf("%0d tokens never produced", tracker.pending()));
        if (tracker.mismatches == 0)
            $display("small_language_tokenizer verification clean");
        else
            $display("small_language_tokenizer verification failed");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #(5_000_000);
        $display("small_language_tokenizer verification failed");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/slt_pkg.sv
hdl/small_language_tokenizer.sv
hdl/slt_checker.sv
verif/testbench.sv
